// ===== sv/tet_pkg.sv =====
// Package for the text edit transform block.
// Holds the edit kind codes, the stage action codes and the inter-stage structs.
// No dependencies.
package tet_pkg;

  localparam int KIND_BITS         = 2;
  localparam int USER_BITS         = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF   = 16;

  // Edit kinds, as coded on the ports
  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DELETE  = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_RETAIN  = 2'd3
  } tet_kind_t;

  // What the last stage does to the local edit
  typedef enum logic [2:0] {
    ACT_PASS,       // unchanged
    ACT_SHIFT_R,    // position moves right by remote length, saturating
    ACT_SHIFT_L,    // position moves left by remote length, floored at zero
    ACT_TO_RSTART,  // position moves to the remote start
    ACT_KEEP_HEAD,  // keep only the bytes before the remote start
    ACT_COVERED,    // fully deleted, becomes retain
    ACT_TRIM_HEAD   // moves to remote start and drops the covered bytes
  } tet_action_t;

  // Stage 1 to stage 2 control
  typedef struct packed {
    tet_kind_t lk;
    tet_kind_t rk;    // remote replace already folded to delete
    logic      pass;
  } tet_ctrl_t;

  // Stage 2 to stage 3 control
  typedef struct packed {
    tet_kind_t   lk;
    tet_action_t act;
  } tet_dec_t;

endpackage

// ===== sv/text_edit_transform.sv =====
// Top level of the text edit transform: three-stage pipeline with valid/stall channels.
// Depends on tet_pkg, tet_prep, tet_cmp and tet_sel.

// Transforms a local text edit against a concurrent remote edit and returns one
// result transaction per input transaction, in order. The pipeline has three register
// stages (span sums, endpoint compares, result select). An accepted input is held in
// the span-sum, compare and select registers in turn; the last of these drives the
// outputs. A new edit pair is taken every cycle while in_stall is low. Each stage
// holds its transaction while the stage after it is full and stalled. Empty stages
// keep filling, so in_stall only rises once all three stages are occupied and
// out_stall is high. Position sums saturate at the top of the position range. A
// shortened edit is described by out_drop leading bytes dropped and out_length bytes kept.
module text_edit_transform #(
  parameter int POSITION_BITS = tet_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tet_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tet_pkg::KIND_BITS-1:0]       in_local_kind,
  input  logic [POSITION_BITS-1:0]            in_local_position,
  input  logic [LENGTH_BITS-1:0]              in_local_length,
  input  logic [tet_pkg::USER_BITS-1:0]       in_local_user,
  input  logic [tet_pkg::KIND_BITS-1:0]       in_remote_kind,
  input  logic [POSITION_BITS-1:0]            in_remote_position,
  input  logic [LENGTH_BITS-1:0]              in_remote_length,
  input  logic [tet_pkg::USER_BITS-1:0]       in_remote_user,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tet_pkg::KIND_BITS-1:0]       out_kind,
  output logic [POSITION_BITS-1:0]            out_position,
  output logic [LENGTH_BITS-1:0]              out_length,
  output logic [LENGTH_BITS-1:0]              out_drop
);
  import tet_pkg::*;

  localparam int WW = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;

  // Stage 1 to 2
  logic                     s1_valid, s1_ready;
  tet_ctrl_t                s1_ctrl;
  logic [POSITION_BITS-1:0] s1_lp, s1_rp, s1_lp_add, s1_lp_sub;
  logic [LENGTH_BITS-1:0]   s1_ll, s1_rl, s1_rp_lp, s1_rend_lp;
  logic [WW-1:0]            s1_lend, s1_rend;

  // Stage 2 to 3
  logic                     s2_valid, s2_ready;
  tet_dec_t                 s2_dec;
  logic [POSITION_BITS-1:0] s2_lp, s2_rp, s2_lp_add, s2_lp_sub;
  logic [LENGTH_BITS-1:0]   s2_ll, s2_rp_lp, s2_rend_lp, s2_ll_trim;

  // Output stage
  logic                     s3_ready;
  tet_kind_t                s3_kind;

  assign in_stall = !s1_ready;
  assign out_kind = s3_kind;

  // Span sums and pass-through flag
  tet_prep #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (in_valid),
    .ready_i   (s2_ready),
    .ready_o   (s1_ready),
    .lk_i      (tet_kind_t'(in_local_kind)),
    .lp_i      (in_local_position),
    .ll_i      (in_local_length),
    .lu_i      (in_local_user),
    .rk_i      (tet_kind_t'(in_remote_kind)),
    .rp_i      (in_remote_position),
    .rl_i      (in_remote_length),
    .ru_i      (in_remote_user),
    .valid_o   (s1_valid),
    .ctrl_o    (s1_ctrl),
    .lp_o      (s1_lp),
    .rp_o      (s1_rp),
    .ll_o      (s1_ll),
    .rl_o      (s1_rl),
    .lend_o    (s1_lend),
    .rend_o    (s1_rend),
    .lp_add_o  (s1_lp_add),
    .lp_sub_o  (s1_lp_sub),
    .rp_lp_o   (s1_rp_lp),
    .rend_lp_o (s1_rend_lp)
  );

  // Endpoint compares and action choice
  tet_cmp #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (s1_valid),
    .ready_i   (s3_ready),
    .ready_o   (s2_ready),
    .ctrl_i    (s1_ctrl),
    .lp_i      (s1_lp),
    .rp_i      (s1_rp),
    .ll_i      (s1_ll),
    .rl_i      (s1_rl),
    .lend_i    (s1_lend),
    .rend_i    (s1_rend),
    .lp_add_i  (s1_lp_add),
    .lp_sub_i  (s1_lp_sub),
    .rp_lp_i   (s1_rp_lp),
    .rend_lp_i (s1_rend_lp),
    .valid_o   (s2_valid),
    .dec_o     (s2_dec),
    .lp_o      (s2_lp),
    .rp_o      (s2_rp),
    .ll_o      (s2_ll),
    .lp_add_o  (s2_lp_add),
    .lp_sub_o  (s2_lp_sub),
    .rp_lp_o   (s2_rp_lp),
    .rend_lp_o (s2_rend_lp),
    .ll_trim_o (s2_ll_trim)
  );

  // Result select and output register
  tet_sel #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_sel (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (s2_valid),
    .ready_i    (!out_stall),
    .ready_o    (s3_ready),
    .dec_i      (s2_dec),
    .lp_i       (s2_lp),
    .rp_i       (s2_rp),
    .ll_i       (s2_ll),
    .lp_add_i   (s2_lp_add),
    .lp_sub_i   (s2_lp_sub),
    .rp_lp_i    (s2_rp_lp),
    .rend_lp_i  (s2_rend_lp),
    .ll_trim_i  (s2_ll_trim),
    .valid_o    (out_valid),
    .kind_o     (s3_kind),
    .position_o (out_position),
    .length_o   (out_length),
    .drop_o     (out_drop)
  );

`ifndef SYNTHESIS
  // Only a trimmed delete drops leading bytes
  a_drop_only_delete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drop != '0)) |-> (s3_kind == KIND_DELETE))
    else $error("non-zero drop on a result that is not a delete");

  // Input backs up only when every stage is full and the output is stalled
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled with an empty stage or a free output");

  // Pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !s1_valid && !s2_valid))
    else $error("valid stage straight after reset");
`endif

endmodule

// ===== sv/tet_prep.sv =====
// Stage 1 of the text edit transform: span ends, shifted positions, pass-through flag.
// Depends on tet_pkg.
module tet_prep #(
  parameter int POSITION_BITS = tet_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tet_pkg::LENGTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  logic                                   ready_i,
  output logic                                   ready_o,
  input  tet_pkg::tet_kind_t                     lk_i,
  input  logic [POSITION_BITS-1:0]               lp_i,
  input  logic [LENGTH_BITS-1:0]                 ll_i,
  input  logic [tet_pkg::USER_BITS-1:0]          lu_i,
  input  tet_pkg::tet_kind_t                     rk_i,
  input  logic [POSITION_BITS-1:0]               rp_i,
  input  logic [LENGTH_BITS-1:0]                 rl_i,
  input  logic [tet_pkg::USER_BITS-1:0]          ru_i,
  output logic                                   valid_o,
  output tet_pkg::tet_ctrl_t                     ctrl_o,
  output logic [POSITION_BITS-1:0]               lp_o,
  output logic [POSITION_BITS-1:0]               rp_o,
  output logic [LENGTH_BITS-1:0]                 ll_o,
  output logic [LENGTH_BITS-1:0]                 rl_o,
  output logic [((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS):0] lend_o,
  output logic [((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS):0] rend_o,
  output logic [POSITION_BITS-1:0]               lp_add_o,
  output logic [POSITION_BITS-1:0]               lp_sub_o,
  output logic [LENGTH_BITS-1:0]                 rp_lp_o,
  output logic [LENGTH_BITS-1:0]                 rend_lp_o
);
  import tet_pkg::*;

  localparam int WW = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;

  logic              valid_r, valid_nxt;
  logic              load;
  tet_ctrl_t         ctrl_nxt, ctrl_r;
  logic [WW-1:0]     lp_w, rp_w, ll_w, rl_w;
  logic [WW-1:0]     lend_nxt, rend_nxt, add_w, sub_w, rp_lp_w, rend_lp_w;
  logic [POSITION_BITS-1:0] lp_add_nxt, lp_sub_nxt;
  logic [POSITION_BITS-1:0] lp_r, rp_r, lp_add_r, lp_sub_r;
  logic [LENGTH_BITS-1:0]   ll_r, rl_r, rp_lp_r, rend_lp_r;
  logic [WW-1:0]            lend_r, rend_r;

  // Handshake: take a new transaction when empty or when the next stage moves
  assign ready_o   = !valid_r || ready_i;
  assign load      = valid_i && ready_o;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  // Operands at common width
  assign lp_w = {{(WW-POSITION_BITS){1'b0}}, lp_i};
  assign rp_w = {{(WW-POSITION_BITS){1'b0}}, rp_i};
  assign ll_w = {{(WW-LENGTH_BITS){1'b0}}, ll_i};
  assign rl_w = {{(WW-LENGTH_BITS){1'b0}}, rl_i};

  // Span ends and shifted positions, all in parallel
  always_comb begin
    lend_nxt  = lp_w + ll_w;
    rend_nxt  = rp_w + rl_w;
    add_w     = lp_w + rl_w;
    sub_w     = lp_w - rl_w;
    rp_lp_w   = rp_w - lp_w;
    rend_lp_w = rend_nxt - lp_w;
    // saturate at the top of the position range
    lp_add_nxt = (|add_w[WW-1:POSITION_BITS]) ? {POSITION_BITS{1'b1}}
                                              : add_w[POSITION_BITS-1:0];
    // floor at zero
    lp_sub_nxt = (lp_w > rl_w) ? sub_w[POSITION_BITS-1:0] : '0;
  end

  // Pass-through flag and remote kind folding
  always_comb begin
    ctrl_nxt.lk   = lk_i;
    ctrl_nxt.rk   = (rk_i == KIND_REPLACE) ? KIND_DELETE : rk_i;
    ctrl_nxt.pass = (lu_i == ru_i) || (lk_i == KIND_RETAIN) || (rk_i == KIND_RETAIN) ||
                    ((lk_i == KIND_REPLACE) && (rk_i == KIND_REPLACE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl_r    <= ctrl_nxt;
      lp_r      <= lp_i;
      rp_r      <= rp_i;
      ll_r      <= ll_i;
      rl_r      <= rl_i;
      lend_r    <= lend_nxt;
      rend_r    <= rend_nxt;
      lp_add_r  <= lp_add_nxt;
      lp_sub_r  <= lp_sub_nxt;
      rp_lp_r   <= rp_lp_w[LENGTH_BITS-1:0];
      rend_lp_r <= rend_lp_w[LENGTH_BITS-1:0];
    end
  end

  assign valid_o   = valid_r;
  assign ctrl_o    = ctrl_r;
  assign lp_o      = lp_r;
  assign rp_o      = rp_r;
  assign ll_o      = ll_r;
  assign rl_o      = rl_r;
  assign lend_o    = lend_r;
  assign rend_o    = rend_r;
  assign lp_add_o  = lp_add_r;
  assign lp_sub_o  = lp_sub_r;
  assign rp_lp_o   = rp_lp_r;
  assign rend_lp_o = rend_lp_r;

endmodule

// ===== sv/tet_cmp.sv =====
// Stage 2 of the text edit transform: endpoint compares and choice of action.
// Depends on tet_pkg.
module tet_cmp #(
  parameter int POSITION_BITS = tet_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tet_pkg::LENGTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  logic                                   ready_i,
  output logic                                   ready_o,
  input  tet_pkg::tet_ctrl_t                     ctrl_i,
  input  logic [POSITION_BITS-1:0]               lp_i,
  input  logic [POSITION_BITS-1:0]               rp_i,
  input  logic [LENGTH_BITS-1:0]                 ll_i,
  input  logic [LENGTH_BITS-1:0]                 rl_i,
  input  logic [((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS):0] lend_i,
  input  logic [((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS):0] rend_i,
  input  logic [POSITION_BITS-1:0]               lp_add_i,
  input  logic [POSITION_BITS-1:0]               lp_sub_i,
  input  logic [LENGTH_BITS-1:0]                 rp_lp_i,
  input  logic [LENGTH_BITS-1:0]                 rend_lp_i,
  output logic                                   valid_o,
  output tet_pkg::tet_dec_t                      dec_o,
  output logic [POSITION_BITS-1:0]               lp_o,
  output logic [POSITION_BITS-1:0]               rp_o,
  output logic [LENGTH_BITS-1:0]                 ll_o,
  output logic [POSITION_BITS-1:0]               lp_add_o,
  output logic [POSITION_BITS-1:0]               lp_sub_o,
  output logic [LENGTH_BITS-1:0]                 rp_lp_o,
  output logic [LENGTH_BITS-1:0]                 rend_lp_o,
  output logic [LENGTH_BITS-1:0]                 ll_trim_o
);
  import tet_pkg::*;

  localparam int WW = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;

  logic              valid_r, valid_nxt;
  logic              load;
  logic [WW-1:0]     lp_w, rp_w;
  logic              lp_gt_rp, lp_ge_rp, lp_lt_rend, lend_gt_rp, lend_le_rend;
  logic              any_empty, rl_nz;
  tet_action_t       act;
  tet_dec_t          dec_nxt, dec_r;
  logic [POSITION_BITS-1:0] lp_r, rp_r, lp_add_r, lp_sub_r;
  logic [LENGTH_BITS-1:0]   ll_r, rp_lp_r, rend_lp_r, ll_trim_r;

  assign ready_o   = !valid_r || ready_i;
  assign load      = valid_i && ready_o;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  // Endpoint compares
  assign lp_w         = {{(WW-POSITION_BITS){1'b0}}, lp_i};
  assign rp_w         = {{(WW-POSITION_BITS){1'b0}}, rp_i};
  assign lp_gt_rp     = lp_i > rp_i;
  assign lp_ge_rp     = lp_i >= rp_i;
  assign lp_lt_rend   = lp_w < rend_i;
  assign lend_gt_rp   = lend_i > rp_w;
  assign lend_le_rend = lend_i <= rend_i;
  assign rl_nz        = rl_i != '0;
  // within an overlap window, the overlap is empty only if one span is empty
  assign any_empty    = (ll_i == '0) || !rl_nz;

  // Action choice
  always_comb begin
    act = ACT_PASS;
    if (!ctrl_i.pass) begin
      case (ctrl_i.lk)
        KIND_INSERT: begin
          if (lp_gt_rp) begin
            if (ctrl_i.rk == KIND_INSERT) act = ACT_SHIFT_R;
            else if (lp_lt_rend)          act = ACT_TO_RSTART;
            else                          act = ACT_SHIFT_L;
          end
        end
        KIND_DELETE: begin
          if (lend_gt_rp) begin
            if (ctrl_i.rk == KIND_INSERT) begin
              if (lp_ge_rp)   act = ACT_SHIFT_R;
              else if (rl_nz) act = ACT_KEEP_HEAD;
            end else if (!lp_lt_rend) begin
              act = ACT_SHIFT_L;
            end else if (any_empty) begin
              if (lp_gt_rp) act = ACT_SHIFT_L;
            end else if (lp_ge_rp && lend_le_rend) begin
              act = ACT_COVERED;
            end else if (!lp_ge_rp) begin
              act = ACT_KEEP_HEAD;
            end else begin
              act = ACT_TRIM_HEAD;
            end
          end
        end
        KIND_REPLACE: begin
          if (lend_gt_rp) begin
            if (ctrl_i.rk == KIND_INSERT) begin
              if (lp_ge_rp) act = ACT_SHIFT_R;
            end else if (!lp_lt_rend) begin
              act = ACT_SHIFT_L;
            end
          end
        end
        default: act = ACT_PASS;
      endcase
    end
  end

  assign dec_nxt.lk  = ctrl_i.lk;
  assign dec_nxt.act = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_r     <= dec_nxt;
      lp_r      <= lp_i;
      rp_r      <= rp_i;
      ll_r      <= ll_i;
      lp_add_r  <= lp_add_i;
      lp_sub_r  <= lp_sub_i;
      rp_lp_r   <= rp_lp_i;
      rend_lp_r <= rend_lp_i;
      ll_trim_r <= ll_i - rend_lp_i;
    end
  end

  assign valid_o   = valid_r;
  assign dec_o     = dec_r;
  assign lp_o      = lp_r;
  assign rp_o      = rp_r;
  assign ll_o      = ll_r;
  assign lp_add_o  = lp_add_r;
  assign lp_sub_o  = lp_sub_r;
  assign rp_lp_o   = rp_lp_r;
  assign rend_lp_o = rend_lp_r;
  assign ll_trim_o = ll_trim_r;

endmodule

// ===== sv/tet_sel.sv =====
// Stage 3 of the text edit transform: result select and output register.
// Depends on tet_pkg.
module tet_sel #(
  parameter int POSITION_BITS = tet_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = tet_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  logic                        ready_i,
  output logic                        ready_o,
  input  tet_pkg::tet_dec_t           dec_i,
  input  logic [POSITION_BITS-1:0]    lp_i,
  input  logic [POSITION_BITS-1:0]    rp_i,
  input  logic [LENGTH_BITS-1:0]      ll_i,
  input  logic [POSITION_BITS-1:0]    lp_add_i,
  input  logic [POSITION_BITS-1:0]    lp_sub_i,
  input  logic [LENGTH_BITS-1:0]      rp_lp_i,
  input  logic [LENGTH_BITS-1:0]      rend_lp_i,
  input  logic [LENGTH_BITS-1:0]      ll_trim_i,
  output logic                        valid_o,
  output tet_pkg::tet_kind_t          kind_o,
  output logic [POSITION_BITS-1:0]    position_o,
  output logic [LENGTH_BITS-1:0]      length_o,
  output logic [LENGTH_BITS-1:0]      drop_o
);
  import tet_pkg::*;

  logic                     valid_r, valid_nxt;
  logic                     load;
  tet_kind_t                kind_nxt, kind_r;
  logic [POSITION_BITS-1:0] pos_nxt, pos_r;
  logic [LENGTH_BITS-1:0]   len_nxt, len_r, drop_nxt, drop_r;

  assign ready_o   = !valid_r || ready_i;
  assign load      = valid_i && ready_o;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  // Result select
  always_comb begin
    kind_nxt = dec_i.lk;
    pos_nxt  = lp_i;
    len_nxt  = ll_i;
    drop_nxt = '0;
    case (dec_i.act)
      ACT_PASS:      ;
      ACT_SHIFT_R:   pos_nxt = lp_add_i;
      ACT_SHIFT_L:   pos_nxt = lp_sub_i;
      ACT_TO_RSTART: pos_nxt = rp_i;
      ACT_KEEP_HEAD: len_nxt = rp_lp_i;
      ACT_COVERED: begin
        kind_nxt = KIND_RETAIN;
        len_nxt  = '0;
      end
      ACT_TRIM_HEAD: begin
        pos_nxt  = rp_i;
        drop_nxt = rend_lp_i;
        len_nxt  = ll_trim_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      drop_r <= drop_nxt;
    end
  end

  assign valid_o    = valid_r;
  assign kind_o     = kind_r;
  assign position_o = pos_r;
  assign length_o   = len_r;
  assign drop_o     = drop_r;

endmodule

// ===== bench/tet_bench_pkg.sv =====
`timescale 1ns / 100ps
// Transaction types and the result checker for the text edit transform bench.
// Depends on tet_pkg for the edit kind codes and the default port widths.
package tet_bench_pkg;
  import tet_pkg::*;

  localparam int POS_W = POSITION_BITS_DEF;
  localparam int LEN_W = LENGTH_BITS_DEF;

  localparam logic [63:0] POS_MAX = (64'd1 << POS_W) - 64'd1;

  // One local/remote edit pair as offered on the input channel
  typedef struct packed {
    tet_kind_t        lk;
    logic [POS_W-1:0] lp;
    logic [LEN_W-1:0] ll;
    logic [15:0]      lu;
    tet_kind_t        rk;
    logic [POS_W-1:0] rp;
    logic [LEN_W-1:0] rl;
    logic [15:0]      ru;
  } edit_pair_t;

  // One transformed edit as seen on the result channel
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_W-1:0]     pos;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     drop;
  } edit_result_t;

  class edit_checker;
    edit_result_t expected_edits[$];
    int unsigned  failures;
    int unsigned  noted;
    int unsigned  checked;
    int unsigned  trimmed;
    int unsigned  covered;
    int unsigned  moved;

    function logic [63:0] sat_pos(logic [63:0] v);
      return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    // Rewrite the local edit so it applies after the remote one
    function edit_result_t transform_edit(edit_pair_t e);
      edit_result_t r;
      tet_kind_t    kind;
      tet_kind_t    rk;
      logic [63:0]  lp, ll, rp, rl, lend, rend, ov_s, ov_e;
      logic [63:0]  pos, len, drop;
      logic         thru;
      lp   = 64'(e.lp);
      ll   = 64'(e.ll);
      rp   = 64'(e.rp);
      rl   = 64'(e.rl);
      lend = lp + ll;
      rend = rp + rl;
      kind = e.lk;
      pos  = lp;
      len  = ll;
      drop = 64'd0;
      thru = (e.lu == e.ru) || e.lk == KIND_RETAIN || e.rk == KIND_RETAIN ||
             (e.lk == KIND_REPLACE && e.rk == KIND_REPLACE);
      // a remote replace behaves as a remote delete
      rk = (e.rk == KIND_REPLACE) ? KIND_DELETE : e.rk;

      if (!thru) begin
        if (e.lk == KIND_INSERT && rk == KIND_INSERT) begin
          if (lp > rp) pos = sat_pos(lp + rl);
        end else if (e.lk == KIND_INSERT) begin
          if (lp > rp) pos = (lp < rend) ? rp : lp - rl;
        end else if (e.lk == KIND_DELETE && rk == KIND_INSERT) begin
          if (lend > rp) begin
            if (lp >= rp) begin
              pos = sat_pos(lp + rl);
            end else if (rl != 64'd0) begin
              len = rp - lp;
            end
          end
        end else if (e.lk == KIND_DELETE) begin
          if (lend > rp) begin
            if (lp >= rend) begin
              pos = lp - rl;
            end else begin
              ov_s = (lp > rp) ? lp : rp;
              ov_e = (lend < rend) ? lend : rend;
              if (ov_s >= ov_e) begin
                // empty overlap: the delete or the remote span is empty
                if (lp > rp) pos = (lp > rl) ? lp - rl : 64'd0;
              end else if (lp >= rp && lend <= rend) begin
                kind = KIND_RETAIN;
                len  = 64'd0;
              end else if (lp < rp) begin
                len = rp - lp;
              end else begin
                pos  = rp;
                drop = rend - lp;
                len  = ll - drop;
              end
            end
          end
        end else begin
          // local replace against remote insert or delete
          if (lend > rp) begin
            if (rk == KIND_INSERT) begin
              if (lp >= rp) pos = sat_pos(lp + rl);
            end else if (lp >= rend) begin
              pos = lp - rl;
            end
          end
        end
      end

      r.kind = kind;
      r.pos  = pos[POS_W-1:0];
      r.len  = len[LEN_W-1:0];
      r.drop = drop[LEN_W-1:0];
      return r;
    endfunction

    // Accepted input transaction: queue its expected result
    function void note_edit(edit_pair_t e);
      edit_result_t r;
      r = transform_edit(e);
      noted++;
      if (r.drop != '0) trimmed++;
      if (r.kind == KIND_RETAIN && e.lk != KIND_RETAIN) covered++;
      if (r.pos != e.lp) moved++;
      expected_edits.push_back(r);
    endfunction

    // Accepted result transaction: compare with the oldest expectation
    function void check_result(edit_result_t got);
      edit_result_t want;
      if (expected_edits.size() == 0) begin
        $error("result with no edit pending: kind %0d position %0d", got.kind, got.pos);
        failures++;
        return;
      end
      want = expected_edits.pop_front();
      checked++;
      if (got.kind !== want.kind) begin
        $error("out_kind: expected %0d, got %0d", want.kind, got.kind);
        failures++;
      end
      if (got.pos !== want.pos) begin
        $error("out_position: expected %0d, got %0d", want.pos, got.pos);
        failures++;
      end
      if (got.len !== want.len) begin
        $error("out_length: expected %0d, got %0d", want.len, got.len);
        failures++;
      end
      if (got.drop !== want.drop) begin
        $error("out_drop: expected %0d, got %0d", want.drop, got.drop);
        failures++;
      end
    endfunction

    function int pending();
      return expected_edits.size();
    endfunction
  endclass

endpackage

// ===== bench/text_edit_transform_test.sv =====
`timescale 1ns / 100ps
// Bench top for text_edit_transform: directed and random edit pairs under random idling.
// Depends on tet_pkg, tet_bench_pkg and the text_edit_transform RTL.
module text_edit_transform_test;
  import tet_pkg::*;
  import tet_bench_pkg::*;

  localparam int RANDOM_EDITS = 700;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_BURST   = 80;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 in_valid           = 1'b0;
  logic                 in_stall;
  logic [KIND_BITS-1:0] in_local_kind      = '0;
  logic [POS_W-1:0]     in_local_position  = '0;
  logic [LEN_W-1:0]     in_local_length    = '0;
  logic [15:0]          in_local_user      = '0;
  logic [KIND_BITS-1:0] in_remote_kind     = '0;
  logic [POS_W-1:0]     in_remote_position = '0;
  logic [LEN_W-1:0]     in_remote_length   = '0;
  logic [15:0]          in_remote_user     = '0;
  logic                 out_valid;
  logic                 out_stall          = 1'b0;
  logic [KIND_BITS-1:0] out_kind;
  logic [POS_W-1:0]     out_position;
  logic [LEN_W-1:0]     out_length;
  logic [LEN_W-1:0]     out_drop;

  logic        hold_req = 1'b0;
  int unsigned cycle_count = 0;
  edit_checker board;

  text_edit_transform #(
    .POSITION_BITS(POS_W),
    .LENGTH_BITS  (LEN_W)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_local_kind     (in_local_kind),
    .in_local_position (in_local_position),
    .in_local_length   (in_local_length),
    .in_local_user     (in_local_user),
    .in_remote_kind    (in_remote_kind),
    .in_remote_position(in_remote_position),
    .in_remote_length  (in_remote_length),
    .in_remote_user    (in_remote_user),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_position      (out_position),
    .out_length        (out_length),
    .out_drop          (out_drop)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic edit_pair_t build_edit(tet_kind_t lk, logic [POS_W-1:0] lp,
                                            logic [LEN_W-1:0] ll, logic [15:0] lu,
                                            tet_kind_t rk, logic [POS_W-1:0] rp,
                                            logic [LEN_W-1:0] rl, logic [15:0] ru);
    edit_pair_t e;
    e.lk = lk;
    e.lp = lp;
    e.ll = ll;
    e.lu = lu;
    e.rk = rk;
    e.rp = rp;
    e.rl = rl;
    e.ru = ru;
    return e;
  endfunction

  // Transaction monitor: both channels sampled on the same edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_edit(build_edit(tet_kind_t'(in_local_kind), in_local_position,
                                 in_local_length, in_local_user,
                                 tet_kind_t'(in_remote_kind), in_remote_position,
                                 in_remote_length, in_remote_user));
    if (rst_n && out_valid && !out_stall)
      board.check_result(edit_result_t'{kind: out_kind, pos: out_position,
                                        len: out_length, drop: out_drop});
  end

  // Receiver: segments of varying stall density, plus a long hold-off on request
  initial begin
    int unsigned stall_pct;
    int unsigned seg_left;
    int unsigned hold_left;
    logic        hold_seen;
    stall_pct = 0;
    seg_left  = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic tet_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return KIND_INSERT;
    if (r < 6) return KIND_DELETE;
    if (r < 9) return KIND_REPLACE;
    return KIND_RETAIN;
  endfunction

  // Mostly distinct users and nearby spans so the edits overlap
  function automatic edit_pair_t random_edit();
    edit_pair_t       e;
    logic [POS_W-1:0] base;
    int unsigned      mode;
    e.lk = pick_kind();
    e.rk = pick_kind();
    e.lu = 16'($urandom);
    e.ru = ($urandom_range(0, 9) == 0) ? e.lu : e.lu + 16'($urandom_range(1, 65535));
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      base = POS_W'($urandom);
      e.lp = base + POS_W'($urandom_range(0, 40));
      e.rp = base + POS_W'($urandom_range(0, 40));
      e.ll = LEN_W'($urandom_range(0, 30));
      e.rl = LEN_W'($urandom_range(0, 30));
    end else if (mode == 7) begin
      // near the top of the position range, so sums saturate
      e.lp = '1 - POS_W'($urandom_range(0, 70000));
      e.rp = '1 - POS_W'($urandom_range(0, 70000));
      e.ll = LEN_W'($urandom);
      e.rl = LEN_W'($urandom);
    end else if (mode == 8) begin
      e.lp = POS_W'($urandom);
      e.rp = POS_W'($urandom);
      e.ll = LEN_W'($urandom);
      e.rl = LEN_W'($urandom);
    end else begin
      // near zero, where left moves are floored
      e.lp = POS_W'($urandom_range(0, 20));
      e.rp = POS_W'($urandom_range(0, 20));
      e.ll = LEN_W'($urandom_range(0, 20));
      e.rl = LEN_W'($urandom_range(0, 20));
    end
    return e;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_edit(input edit_pair_t e);
    in_valid           <= 1'b1;
    in_local_kind      <= e.lk;
    in_local_position  <= e.lp;
    in_local_length    <= e.ll;
    in_local_user      <= e.lu;
    in_remote_kind     <= e.rk;
    in_remote_position <= e.rp;
    in_remote_length   <= e.rl;
    in_remote_user     <= e.ru;
    do @(posedge clk); while (in_stall);
  endtask

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned burst_left;
    int unsigned n_directed;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through cases
    send_edit(build_edit(KIND_INSERT, 20, 3, 7, KIND_INSERT, 10, 5, 7));
    send_edit(build_edit(KIND_RETAIN, 20, 3, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 20, 3, 1, KIND_RETAIN, 10, 5, 2));
    send_edit(build_edit(KIND_REPLACE, 20, 3, 1, KIND_REPLACE, 10, 5, 2));
    // insert against insert, including saturation
    send_edit(build_edit(KIND_INSERT, 10, 3, 1, KIND_INSERT, 10, 5, 2));
    send_edit(build_edit(KIND_INSERT, 20, 3, 1, KIND_INSERT, 10, 5, 2));
    send_edit(build_edit(KIND_INSERT, 32'hFFFF_FFF0, 0, 1, KIND_INSERT, 5, 16'hFFFF, 2));
    // insert against delete, and against a replace taken as delete
    send_edit(build_edit(KIND_INSERT, 12, 1, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_INSERT, 30, 1, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_INSERT, 30, 1, 1, KIND_REPLACE, 10, 5, 2));
    // delete against insert
    send_edit(build_edit(KIND_DELETE, 0, 5, 1, KIND_INSERT, 5, 3, 2));
    send_edit(build_edit(KIND_DELETE, 5, 4, 1, KIND_INSERT, 5, 3, 2));
    send_edit(build_edit(KIND_DELETE, 2, 6, 1, KIND_INSERT, 5, 3, 2));
    send_edit(build_edit(KIND_DELETE, 2, 6, 1, KIND_INSERT, 5, 0, 2));
    // delete against delete
    send_edit(build_edit(KIND_DELETE, 0, 4, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 20, 4, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 11, 3, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 8, 4, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 12, 10, 1, KIND_DELETE, 10, 5, 2));
    // empty delete inside a remote delete, with and without the floor
    send_edit(build_edit(KIND_DELETE, 12, 0, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_DELETE, 3, 0, 1, KIND_DELETE, 0, 10, 2));
    // replace against insert or delete
    send_edit(build_edit(KIND_REPLACE, 10, 4, 1, KIND_INSERT, 5, 3, 2));
    send_edit(build_edit(KIND_REPLACE, 30, 4, 1, KIND_DELETE, 10, 5, 2));
    send_edit(build_edit(KIND_REPLACE, 8, 4, 1, KIND_DELETE, 10, 5, 2));
    // all ones and all zeros
    send_edit(build_edit(KIND_DELETE, '1, '1, 16'hFFFF, KIND_INSERT, '1, '1, 16'h0000));
    send_edit(build_edit(KIND_INSERT, '0, '0, 16'h0000, KIND_INSERT, '0, '0, 16'h0000));
    n_directed = board.noted;

    // random bursts with random gaps
    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_EDITS) begin
      if (sent == 250) begin
        // receiver holds off while the sender keeps the input busy
        hold_req = 1'b1;
        repeat (HOLD_BURST) begin
          send_edit(random_edit());
          sent++;
        end
      end else if (sent == 480) begin
        // pause until the pipeline has emptied
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        burst_left = 1;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      send_edit(random_edit());
      sent++;
      burst_left--;
    end

    // drain
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Transformed %0d edit pairs (%0d directed), %0d results checked.",
             board.noted, n_directed, board.checked);
    $display("Of these %0d moved, %0d trimmed at the head, %0d fully covered.",
             board.moved, board.trimmed, board.covered);
    if (board.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tet_pkg.sv
sv/tet_prep.sv
sv/tet_cmp.sv
sv/tet_sel.sv
sv/text_edit_transform.sv
bench/tet_bench_pkg.sv
bench/text_edit_transform_test.sv
